// ----- hdl/eu8d_pkg.sv -----
// ----------------------------------------------------------------------------
// eu8d_pkg
// Types and constants shared by the extended utf-8 sequence decoder.
// ----------------------------------------------------------------------------
package eu8d_pkg;

  localparam int unsigned WIN_BYTES   = 9;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned CP_W        = 64;
  localparam int unsigned IN_TDATA_W  = 80;  // 72 window bits + 4 count bits, byte padded
  localparam int unsigned OUT_TDATA_W = 72;  // 4 count bits + 64 value bits, byte padded

  localparam logic [7:0] EXT_LEAD      = 8'hFE;
  localparam logic [7:0] RESERVED_LEAD = 8'hFF;
  localparam logic [7:0] CONT_MASK     = 8'hC0;
  localparam logic [7:0] CONT_TAG      = 8'h80;
  localparam logic [7:0] LEAD2_MASK    = 8'hE0;
  localparam logic [7:0] LEAD2_TAG     = 8'hC0;
  localparam logic [7:0] LEAD3_MASK    = 8'hF0;
  localparam logic [7:0] LEAD3_TAG     = 8'hE0;
  localparam logic [7:0] LEAD4_MASK    = 8'hF8;
  localparam logic [7:0] LEAD4_TAG     = 8'hF0;
  localparam logic [7:0] LEAD5_MASK    = 8'hFC;
  localparam logic [7:0] LEAD5_TAG     = 8'hF8;
  localparam logic [7:0] LEAD6_MASK    = 8'hFE;
  localparam logic [7:0] LEAD6_TAG     = 8'hFC;

  localparam logic [CNT_W-1:0] MAX_AVAIL = CNT_W'(WIN_BYTES);

  typedef logic [WIN_BYTES-1:0][7:0] byte_win_t;

  typedef enum logic [2:0] {
    FORM_1,
    FORM_2,
    FORM_3,
    FORM_4,
    FORM_5,
    FORM_6,
    FORM_EXT,
    FORM_BAD
  } form_t;

  typedef struct packed {
    logic [CNT_W-1:0] bytes_consumed;
    logic [CP_W-1:0]  code_point;
  } dec_result_t;

endpackage

// ----- hdl/eu8d_decode.sv -----
// ----------------------------------------------------------------------------
// eu8d_decode
// Combinational decode of one character from a nine-byte window.
// ----------------------------------------------------------------------------
module eu8d_decode
  import eu8d_pkg::*;
(
  input  byte_win_t        win,
  input  logic [CNT_W-1:0] bytes_available,
  output dec_result_t      result
);

  logic [CNT_W-1:0]     avail;
  logic [7:0]           lead;
  form_t                form;
  logic [CNT_W-1:0]     need;
  logic [WIN_BYTES-1:0] cont_ok;
  logic                 conts_good;
  logic [CP_W-1:0]      value;
  logic                 ok;

  assign avail = (bytes_available > MAX_AVAIL) ? MAX_AVAIL : bytes_available;
  assign lead  = win[0];

  always_comb begin
    for (int i = 0; i < WIN_BYTES; i++) begin
      cont_ok[i] = (win[i] & CONT_MASK) == CONT_TAG;
    end
  end

  always_comb begin
    priority if (lead == RESERVED_LEAD) begin
      form = FORM_BAD;
    end else if (lead == EXT_LEAD) begin
      form = FORM_EXT;
    end else if (!lead[7]) begin
      form = FORM_1;
    end else if ((lead & LEAD2_MASK) == LEAD2_TAG) begin
      form = FORM_2;
    end else if ((lead & LEAD3_MASK) == LEAD3_TAG) begin
      form = FORM_3;
    end else if ((lead & LEAD4_MASK) == LEAD4_TAG) begin
      form = FORM_4;
    end else if ((lead & LEAD5_MASK) == LEAD5_TAG) begin
      form = FORM_5;
    end else if ((lead & LEAD6_MASK) == LEAD6_TAG) begin
      form = FORM_6;
    end else begin
      form = FORM_BAD;
    end
  end

  always_comb begin
    need       = '0;
    conts_good = 1'b0;
    value      = '0;
    unique case (form)
      FORM_1: begin
        need       = CNT_W'(1);
        conts_good = 1'b1;
        value      = CP_W'(lead[6:0]);
      end
      FORM_2: begin
        need       = CNT_W'(2);
        conts_good = cont_ok[1];
        value      = CP_W'({lead[4:0], win[1][5:0]});
      end
      FORM_3: begin
        need       = CNT_W'(3);
        conts_good = &cont_ok[2:1];
        value      = CP_W'({lead[3:0], win[1][5:0], win[2][5:0]});
      end
      FORM_4: begin
        need       = CNT_W'(4);
        conts_good = &cont_ok[3:1];
        value      = CP_W'({lead[2:0], win[1][5:0], win[2][5:0], win[3][5:0]});
      end
      FORM_5: begin
        need       = CNT_W'(5);
        conts_good = &cont_ok[4:1];
        value      = CP_W'({lead[1:0], win[1][5:0], win[2][5:0], win[3][5:0],
                            win[4][5:0]});
      end
      FORM_6: begin
        need       = CNT_W'(6);
        conts_good = &cont_ok[5:1];
        value      = CP_W'({lead[0], win[1][5:0], win[2][5:0], win[3][5:0],
                            win[4][5:0], win[5][5:0]});
      end
      FORM_EXT: begin
        // payload bytes are big endian and unchecked
        need       = MAX_AVAIL;
        conts_good = 1'b1;
        value      = {win[1], win[2], win[3], win[4], win[5], win[6], win[7], win[8]};
      end
      FORM_BAD: begin
        need       = '0;
        conts_good = 1'b0;
        value      = '0;
      end
      default: begin
        need       = '0;
        conts_good = 1'b0;
        value      = '0;
      end
    endcase
  end

  // empty window fails here too since need is never zero on a good form
  assign ok = conts_good && (avail >= need);

  assign result.bytes_consumed = ok ? need : '0;
  assign result.code_point     = ok ? value : '0;

endmodule

// ----- hdl/extended_utf8_sequence_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// extended_utf8_sequence_decoder_unit
// Decodes one original-form utf-8 character (1 to 6 bytes) or a 0xFE-led
// 9-byte 64-bit form from a window of nine bytes per word.
// ----------------------------------------------------------------------------
// channel | direction | tdata fields (lowest bit up)
// in_     | slave     | nine window bytes [71:0], bytes_available [75:72], pad
// out_    | master    | bytes_consumed [3:0], code_point [67:4], pad
//
// one word per cycle sustained while out_tready stays high; each word passes
// the input register, decode logic and output register, in that order
// synchronous active-low reset clears both valid flags only
// a stalled output holds its word; the input register refills in the same
// cycle the output register drains, so only a full stall backs up in_tready
// ----------------------------------------------------------------------------
module extended_utf8_sequence_decoder_unit
  import eu8d_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // lead_byte, second..ninth_byte, bytes_available
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // bytes_consumed, code_point
);

  logic             in_valid_r;
  byte_win_t        win_r;
  logic [CNT_W-1:0] avail_r;
  logic             out_valid_r;
  dec_result_t      res_r;
  dec_result_t      res_nxt;
  logic             out_free;
  logic             stage_adv;

  assign out_free  = !out_valid_r || out_tready;
  assign stage_adv = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      win_r   <= in_tdata[WIN_BYTES*8-1:0];
      avail_r <= in_tdata[WIN_BYTES*8 +: CNT_W];
    end
  end

  eu8d_decode u_decode (
    .win             (win_r),
    .bytes_available (avail_r),
    .result          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W-CNT_W-CP_W)'(0), res_r.code_point, res_r.bytes_consumed};

endmodule
